/* rtl/fpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_pkg: shared types and constants for frustum plane extraction
// Widths, beat structs, datapath command codes and saturation helpers.
// ----------------------------------------------------------------------------
package fpe_pkg;

  // Fixed-point format and derived widths.
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SHP_W      = PROD_W - FRAC_BITS;
  localparam int ACC_W      = SHP_W + 2;
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  localparam int ITER_W     = $clog2(NUM_W);
  localparam int ROOT_STEPS = DATA_W;
  localparam int MAT_DEPTH  = 16;
  localparam int ADDR_W     = $clog2(MAT_DEPTH);

  localparam logic [2:0] LAST_PLANE = 3'd5;

  // Input beat: one matrix element write, optionally with a compute request.
  typedef struct packed {
    logic                     matrix_select;
    logic [3:0]               element_index;
    logic signed [DATA_W-1:0] element_value;
    logic                     compute_now;
  } in_item_t;

  // Result beat: one normalized plane.
  typedef struct packed {
    logic [2:0]               plane_index;
    logic signed [DATA_W-1:0] plane_a;
    logic signed [DATA_W-1:0] plane_b;
    logic signed [DATA_W-1:0] plane_c;
    logic signed [DATA_W-1:0] plane_dist;
    logic                     degenerate;
    logic                     last_plane;
  } out_item_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_MAC_MUL,
    DP_MAC_ACC,
    DP_COMP,
    DP_SQ_MUL,
    DP_SQ_ACC,
    DP_ROOT_INIT,
    DP_ROOT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_END
  } dp_op_e;

  // Command group from the controller to the datapath.
  typedef struct packed {
    dp_op_e            op;
    logic              load;
    logic [1:0]        sel;
    logic              first;
    logic              last;
    logic              sub;
    logic [ADDR_W-1:0] mv_addr;
    logic [ADDR_W-1:0] pj_addr;
    logic [ADDR_W-1:0] clip_waddr;
    logic [ADDR_W-1:0] clip_raddr_a;
    logic [ADDR_W-1:0] clip_raddr_b;
  } dp_cmd_t;

  // Status group from the datapath to the controller.
  typedef struct packed {
    logic sq_zero;
  } dp_stat_t;

  // Saturate an accumulator sum to 32-bit signed.
  function automatic logic [DATA_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) return v[DATA_W-1:0];
    else if (v[ACC_W-1])   return {1'b1, {(DATA_W-1){1'b0}}};
    else                   return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  // Saturate a 33-bit sum or difference to 32-bit signed.
  function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] v);
    if (v[DATA_W] == v[DATA_W-1]) return v[DATA_W-1:0];
    else if (v[DATA_W])           return {1'b1, {(DATA_W-1){1'b0}}};
    else                          return {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  // Planes right, top and far subtract the column from column 3.
  function automatic logic plane_sub(input logic [2:0] p);
    case (p)
      3'd0:    return 1'b1;
      3'd3:    return 1'b1;
      3'd4:    return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

/* rtl/fpe_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fpe_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_dp: frustum plane extraction datapath
// Matrix stores, shared multiplier, accumulator, square root and divider.
// ----------------------------------------------------------------------------
module fpe_dp (
  input  logic              clk_i,
  input  fpe_pkg::in_item_t item_i,
  input  fpe_pkg::dp_cmd_t  cmd_i,
  output fpe_pkg::dp_stat_t stat_o,
  output logic [31:0]       plane_a_o,
  output logic [31:0]       plane_b_o,
  output logic [31:0]       plane_c_o,
  output logic [31:0]       plane_dist_o
);
  import fpe_pkg::*;

  logic [DATA_W-1:0] mv_rd, pj_rd, clip_a_rd, clip_b_rd;
  logic [DATA_W-1:0] clip_wdata;
  logic              clip_we;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic [ACC_W-1:0]         acc_q, acc_sum, shp_ext;
  logic [DATA_W-1:0]        comp_q [4];
  logic [DATA_W-1:0]        res_q  [4];
  logic [DATA_W:0]          ca, cb, csum;
  logic [PROD_W-1:0]        sq_q, rsh_q;
  logic [DATA_W:0]          rrem_q;
  logic [DATA_W+2:0]        rrem_t, rtrial, rdiff;
  logic [DATA_W-1:0]        root_q;
  logic [NUM_W-1:0]         num_q, quo_q;
  logic [DATA_W-1:0]        drem_q, mag;
  logic [DATA_W:0]          drem_t, ddiff;
  logic                     neg_q;
  logic [DATA_W-1:0]        sel_comp, div_res;

  // Matrix and clip stores; the clip store is kept twice for two reads.
  fpe_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_proj (
    .clk_i, .we_i(cmd_i.load && !item_i.matrix_select),
    .waddr_i(item_i.element_index), .wdata_i(item_i.element_value),
    .raddr_i(cmd_i.pj_addr), .rdata_o(pj_rd)
  );
  fpe_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_modl (
    .clk_i, .we_i(cmd_i.load && item_i.matrix_select),
    .waddr_i(item_i.element_index), .wdata_i(item_i.element_value),
    .raddr_i(cmd_i.mv_addr), .rdata_o(mv_rd)
  );
  fpe_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_clip_a (
    .clk_i, .we_i(clip_we), .waddr_i(cmd_i.clip_waddr), .wdata_i(clip_wdata),
    .raddr_i(cmd_i.clip_raddr_a), .rdata_o(clip_a_rd)
  );
  fpe_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_clip_b (
    .clk_i, .we_i(clip_we), .waddr_i(cmd_i.clip_waddr), .wdata_i(clip_wdata),
    .raddr_i(cmd_i.clip_raddr_b), .rdata_o(clip_b_rd)
  );

  // Operand selection for the shared multiplier.
  assign sel_comp = comp_q[cmd_i.sel];
  assign mul_a = (cmd_i.op == DP_MAC_MUL) ? mv_rd : sel_comp;
  assign mul_b = (cmd_i.op == DP_MAC_MUL) ? pj_rd : sel_comp;

  // Floor-shifted product, sign-extended into the accumulator.
  assign shp_ext = {{2{prod_q[PROD_W-1]}}, prod_q[PROD_W-1:FRAC_BITS]};
  assign acc_sum = (cmd_i.first ? '0 : acc_q) + shp_ext;
  assign clip_we    = (cmd_i.op == DP_MAC_ACC) && cmd_i.last;
  assign clip_wdata = sat_acc(acc_sum);

  // Plane component: column 3 plus or minus the chosen column.
  assign ca   = {clip_a_rd[DATA_W-1], clip_a_rd};
  assign cb   = {clip_b_rd[DATA_W-1], clip_b_rd};
  assign csum = cmd_i.sub ? (ca - cb) : (ca + cb);

  // One root digit: bring down two bits, compare against the trial value.
  assign rrem_t = {rrem_q, rsh_q[PROD_W-1:PROD_W-2]};
  assign rtrial = {1'b0, root_q, 2'b01};
  assign rdiff  = rrem_t - rtrial;

  // One quotient bit of the restoring divider.
  assign drem_t = {drem_q, num_q[NUM_W-1]};
  assign ddiff  = drem_t - {1'b0, root_q};
  assign mag    = sel_comp[DATA_W-1] ? (DATA_W'(0) - sel_comp) : sel_comp;

  // Saturated, signed quotient.
  always_comb begin
    if (neg_q) begin
      if (quo_q > {{FRAC_BITS{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}) begin
        div_res = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        div_res = DATA_W'(0) - quo_q[DATA_W-1:0];
      end
    end else begin
      if (quo_q > {{FRAC_BITS{1'b0}}, 1'b0, {(DATA_W-1){1'b1}}}) begin
        div_res = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        div_res = quo_q[DATA_W-1:0];
      end
    end
  end

  // Datapath registers, driven by the command of the cycle.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_MAC_MUL, DP_SQ_MUL: begin
        prod_q <= mul_a * mul_b;
      end
      DP_MAC_ACC: begin
        acc_q <= acc_sum;
      end
      DP_COMP: begin
        comp_q[cmd_i.sel] <= sat_sum(csum);
      end
      DP_SQ_ACC: begin
        sq_q <= (cmd_i.first ? '0 : sq_q) + prod_q;
      end
      DP_ROOT_INIT: begin
        rsh_q  <= sq_q;
        rrem_q <= '0;
        root_q <= '0;
      end
      DP_ROOT_STEP: begin
        rsh_q <= {rsh_q[PROD_W-3:0], 2'b00};
        if (rrem_t >= rtrial) begin
          rrem_q <= rdiff[DATA_W:0];
          root_q <= {root_q[DATA_W-2:0], 1'b1};
        end else begin
          rrem_q <= rrem_t[DATA_W:0];
          root_q <= {root_q[DATA_W-2:0], 1'b0};
        end
      end
      DP_DIV_INIT: begin
        neg_q  <= sel_comp[DATA_W-1];
        num_q  <= {mag, {FRAC_BITS{1'b0}}};
        drem_q <= '0;
        quo_q  <= '0;
      end
      DP_DIV_STEP: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        if (drem_t >= {1'b0, root_q}) begin
          drem_q <= ddiff[DATA_W-1:0];
          quo_q  <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          drem_q <= drem_t[DATA_W-1:0];
          quo_q  <= {quo_q[NUM_W-2:0], 1'b0};
        end
      end
      DP_DIV_END: begin
        res_q[cmd_i.sel] <= div_res;
      end
      default: begin
      end
    endcase
  end

  // A zero normal forces the plane to zero.
  assign stat_o.sq_zero = (sq_q == '0);
  assign plane_a_o    = stat_o.sq_zero ? '0 : res_q[0];
  assign plane_b_o    = stat_o.sq_zero ? '0 : res_q[1];
  assign plane_c_o    = stat_o.sq_zero ? '0 : res_q[2];
  assign plane_dist_o = stat_o.sq_zero ? '0 : res_q[3];

endmodule

/* rtl/fpe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpe_ctrl: frustum plane extraction controller
// Sequences the clip product, plane components, root and divisions.
// ----------------------------------------------------------------------------
module fpe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              compute_i,
  input  fpe_pkg::dp_stat_t stat_i,
  output logic              busy,
  output fpe_pkg::dp_cmd_t  cmd_o,
  output logic              valid_o,
  output logic [2:0]        plane_o
);
  import fpe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CL_RD, S_CL_MUL, S_CL_ACC, S_PL_RD, S_PL_CMP, S_SQ_MUL, S_SQ_ACC,
    S_RT_INIT, S_RT_STEP, S_DV_INIT, S_DV_STEP, S_DV_END, S_EMIT
  } state_e;

  state_e            state_q;
  logic [3:0]        e_q;
  logic [1:0]        k_q;
  logic [2:0]        p_q;
  logic [ITER_W-1:0] it_q;
  logic              accept;

  assign accept = start && (state_q == S_IDLE);

  // State, counters and the registered result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      e_q     <= '0;
      k_q     <= '0;
      p_q     <= '0;
      it_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && compute_i) begin
            state_q <= S_CL_RD;
            e_q     <= '0;
            k_q     <= '0;
          end
        end
        S_CL_RD:  state_q <= S_CL_MUL;
        S_CL_MUL: state_q <= S_CL_ACC;
        S_CL_ACC: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3 && e_q == 4'd15) begin
            state_q <= S_PL_RD;
            p_q     <= '0;
          end else begin
            state_q <= S_CL_RD;
            if (k_q == 2'd3) e_q <= e_q + 4'd1;
          end
        end
        S_PL_RD:  state_q <= S_PL_CMP;
        S_PL_CMP: begin
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_SQ_MUL : S_PL_RD;
        end
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= S_RT_INIT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_SQ_MUL;
          end
        end
        S_RT_INIT: begin
          it_q    <= '0;
          state_q <= S_RT_STEP;
        end
        S_RT_STEP: begin
          it_q <= it_q + ITER_W'(1);
          if (it_q == ITER_W'(ROOT_STEPS - 1)) begin
            state_q <= stat_i.sq_zero ? S_EMIT : S_DV_INIT;
          end
        end
        S_DV_INIT: begin
          it_q    <= '0;
          state_q <= S_DV_STEP;
        end
        S_DV_STEP: begin
          it_q <= it_q + ITER_W'(1);
          if (it_q == ITER_W'(NUM_W - 1)) state_q <= S_DV_END;
        end
        S_DV_END: begin
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? S_EMIT : S_DV_INIT;
        end
        S_EMIT: begin
          k_q <= '0;
          if (p_q == LAST_PLANE) begin
            state_q <= S_IDLE;
          end else begin
            p_q     <= p_q + 3'd1;
            state_q <= S_PL_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Command decode from state and counters.
  always_comb begin
    cmd_o              = '0;
    cmd_o.op           = DP_NOP;
    cmd_o.load         = accept;
    cmd_o.sel          = k_q;
    cmd_o.first        = (k_q == 2'd0);
    cmd_o.last         = (k_q == 2'd3);
    cmd_o.sub          = plane_sub(p_q);
    cmd_o.mv_addr      = {e_q[3:2], k_q};
    cmd_o.pj_addr      = {k_q, e_q[1:0]};
    cmd_o.clip_waddr   = e_q;
    cmd_o.clip_raddr_a = {k_q, 2'd3};
    cmd_o.clip_raddr_b = {k_q, p_q[2:1]};
    case (state_q)
      S_CL_MUL:  cmd_o.op = DP_MAC_MUL;
      S_CL_ACC:  cmd_o.op = DP_MAC_ACC;
      S_PL_CMP:  cmd_o.op = DP_COMP;
      S_SQ_MUL:  cmd_o.op = DP_SQ_MUL;
      S_SQ_ACC:  cmd_o.op = DP_SQ_ACC;
      S_RT_INIT: cmd_o.op = DP_ROOT_INIT;
      S_RT_STEP: cmd_o.op = DP_ROOT_STEP;
      S_DV_INIT: cmd_o.op = DP_DIV_INIT;
      S_DV_STEP: cmd_o.op = DP_DIV_STEP;
      S_DV_END:  cmd_o.op = DP_DIV_END;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_EMIT);
  assign plane_o = p_q;

  // The strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held two cycles");

  // The sixth plane ends the run.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && p_q == LAST_PLANE) |=> !busy) else $error("run did not end");

  // A compute request makes the block busy.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && compute_i) |=> busy) else $error("compute request dropped");

  // Root iteration stays in range.
  a_root_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RT_STEP) |-> (it_q < ITER_W'(ROOT_STEPS)))
    else $error("root iteration overrun");

endmodule

/* rtl/frustum_plane_extract.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_extract: view-frustum plane extraction in fixed point
// Loads two 4x4 matrices, forms the clip matrix and emits six normal planes.
// ----------------------------------------------------------------------------
// A load without a compute request leaves busy low.
// A compute run forms the clip matrix with 64 multiply-accumulates, then
// takes a square root and four divides per plane (the divides are skipped
// for a zero normal), for six planes in turn.
// Each plane is strobed for one cycle; the receiver cannot stall.
// Reset clears the controller only; matrix contents hold until written.
module frustum_plane_extract (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fpe_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output fpe_pkg::out_item_t result_o
);
  import fpe_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  plane;
  logic [31:0] pa, pb, pc, pd;

  // Sequencing.
  fpe_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .compute_i(item_i.compute_now), .stat_i(stat),
    .busy, .cmd_o(cmd), .valid_o(result_valid_o), .plane_o(plane)
  );

  // Arithmetic and storage.
  fpe_dp u_dp (
    .clk_i, .item_i, .cmd_i(cmd), .stat_o(stat),
    .plane_a_o(pa), .plane_b_o(pb), .plane_c_o(pc), .plane_dist_o(pd)
  );

  // Result beat assembly.
  assign result_o.plane_index = plane;
  assign result_o.plane_a     = pa;
  assign result_o.plane_b     = pb;
  assign result_o.plane_c     = pc;
  assign result_o.plane_dist  = pd;
  assign result_o.degenerate  = stat.sq_zero;
  assign result_o.last_plane  = (plane == LAST_PLANE);

endmodule

/* tb/frustum_plane_extract_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_plane_extract_tb: self-checking bench for frustum plane extraction
// Loads projection and modelview elements, requests compute runs and checks
// every emitted plane against a bit-accurate fixed-point predictor.
// ----------------------------------------------------------------------------
module frustum_plane_extract_tb;
  import fpe_pkg::*;

  localparam int NUM_RANDOM = 400;

  // Directed row: one load beat, with an optional typed-in plane set.
  typedef struct {
    logic        mv;
    logic [3:0]  idx;
    logic [31:0] val;
    logic        go;
    logic        has_planes;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [31:0] pc;
    logic [31:0] pd;
    logic        degen;
  } load_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      result_valid_o;
  out_item_t result_o;

  // Predictor copy of the matrix stores.
  logic signed [31:0] proj_m [16];
  logic signed [31:0] modl_m [16];
  bit                 proj_written [16];
  bit                 modl_written [16];

  out_item_t plane_q [$];
  int        mismatches = 0;
  int        planes_seen = 0;
  int        beats_sent = 0;
  int        runs_sent = 0;
  int        degen_seen = 0;

  frustum_plane_extract DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Run limit: even if every beat started a compute run behind the longest
  // gap, 450 beats would finish well inside this time.
  initial begin
    #10000000;
    $display("frustum_plane_extract_tb failed");
    $finish;
  end

  function automatic logic signed [31:0] sat_to32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] normalize(input logic signed [31:0] x,
                                                  input logic [63:0] len);
    logic [63:0] ux;
    logic [63:0] q;
    ux = (x < 0) ? 64'(-64'(x)) : 64'(x);
    q = (ux << FRAC_BITS) / len;
    if (x < 0) begin
      if (q > 64'h80000000) q = 64'h80000000;
      return 32'(-q);
    end
    if (q > 64'h7fffffff) q = 64'h7fffffff;
    return q[31:0];
  endfunction

  // Clip matrix, then six normalized planes queued in emission order.
  task automatic predict_planes();
    logic signed [31:0] clip [16];
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic signed [31:0] comp [4];
    logic [63:0]        sq;
    logic [63:0]        len;
    int                 col;
    out_item_t          pl;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = 64'(modl_m[4*i+k]) * 64'(proj_m[4*k+j]);
          acc = acc + (prod >>> FRAC_BITS);
        end
        clip[4*i+j] = sat_to32(acc);
      end
    end
    for (int p = 0; p < 6; p++) begin
      col = p / 2;
      for (int k = 0; k < 4; k++) begin
        if (plane_sub(3'(p)))
          comp[k] = sat_to32(64'(clip[4*k+3]) - 64'(clip[4*k+col]));
        else
          comp[k] = sat_to32(64'(clip[4*k+3]) + 64'(clip[4*k+col]));
      end
      sq = 0;
      for (int k = 0; k < 3; k++) sq = sq + 64'(64'(comp[k]) * 64'(comp[k]));
      len = isqrt(sq);
      pl = '0;
      pl.plane_index = 3'(p);
      pl.degenerate = (sq == 0);
      pl.last_plane = (p == 5);
      if (sq != 0) begin
        pl.plane_a = normalize(comp[0], len);
        pl.plane_b = normalize(comp[1], len);
        pl.plane_c = normalize(comp[2], len);
        pl.plane_dist = normalize(comp[3], len);
      end
      plane_q.push_back(pl);
    end
  endtask

  // Result checking on every strobe against the oldest expected plane.
  always @(posedge clk_i) begin
    out_item_t want;
    if (result_valid_o) begin
      planes_seen++;
      if (result_o.degenerate) degen_seen++;
      if (plane_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected plane beat %p", result_o);
      end else begin
        want = plane_q.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("plane mismatch: expected %p got %p", want, result_o);
        end
      end
    end
  end

  // Drop start for a random number of cycles, if any.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send one load beat; update the predictor when it is accepted.
  task automatic send_load(input logic mv, input logic [3:0] idx,
                           input logic [31:0] val, input logic go);
    in_item_t it;
    it.matrix_select = mv;
    it.element_index = idx;
    it.element_value = val;
    it.compute_now = go;
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    beats_sent++;
    if (mv) begin
      modl_m[idx] = val;
      modl_written[idx] = 1'b1;
    end else begin
      proj_m[idx] = val;
      proj_written[idx] = 1'b1;
    end
    if (go) begin
      runs_sent++;
      predict_planes();
    end
    if ($urandom_range(0, 3) != 0) idle_gap();
  endtask

  function automatic bit all_written();
    for (int i = 0; i < 16; i++)
      if (!proj_written[i] || !modl_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'h00010000;
      2:       return 32'hffff0000;
      3:       return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      4:       return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return 0;
    endcase
  endfunction

  load_row_t rows [$];
  load_row_t r;

  initial begin
    // Directed part: identity matrices, then extremes.
    for (int i = 0; i < 16; i++) begin
      r = '{1'b0, 4'(i), (i % 5 == 0) ? 32'h00010000 : 32'h0, 1'b0,
            1'b0, 0, 0, 0, 0, 1'b0};
      rows.push_back(r);
    end
    for (int i = 0; i < 15; i++) begin
      r = '{1'b1, 4'(i), (i % 5 == 0) ? 32'h00010000 : 32'h0, 1'b0,
            1'b0, 0, 0, 0, 0, 1'b0};
      rows.push_back(r);
    end
    // Identity clip: right plane is (-1, 0, 0, 1).
    r = '{1'b1, 4'd15, 32'h00010000, 1'b1, 1'b1,
          32'hffff0000, 32'h0, 32'h0, 32'h00010000, 1'b0};
    rows.push_back(r);
    // An all-zero modelview gives zero planes.
    for (int i = 0; i < 16; i++) begin
      r = '{1'b1, 4'(i), 32'h0, (i == 15), (i == 15), 0, 0, 0, 0, 1'b1};
      rows.push_back(r);
    end
    r = '{1'b1, 4'd0, 32'h7fffffff, 1'b0, 1'b0, 0, 0, 0, 0, 1'b0};
    rows.push_back(r);
    r = '{1'b0, 4'd15, 32'h80000000, 1'b1, 1'b0, 0, 0, 0, 0, 1'b0};
    rows.push_back(r);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[n]) begin
      send_load(rows[n].mv, rows[n].idx, rows[n].val, rows[n].go);
      if (rows[n].has_planes) begin
        // The run just queued sits at the back; typed values cover the first
        // plane, or every plane of a degenerate run.
        for (int p = 0; p < 6; p++) begin
          out_item_t typed;
          out_item_t queued;
          queued = plane_q[plane_q.size() - 6 + p];
          typed = '0;
          typed.plane_index = 3'(p);
          typed.degenerate = rows[n].degen;
          typed.last_plane = (p == 5);
          if (!rows[n].degen) begin
            typed.plane_a = rows[n].pa;
            typed.plane_b = rows[n].pb;
            typed.plane_c = rows[n].pc;
            typed.plane_dist = rows[n].pd;
          end
          if ((p == 0 || rows[n].degen) && queued !== typed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("predictor disagrees: typed %p predicted %p", typed, queued);
          end
        end
      end
    end

    // Pause until every expected plane has arrived.
    start <= 1'b0;
    while (plane_q.size() != 0) @(posedge clk_i);

    // Random part: mostly loads, compute requests now and then.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      logic go;
      go = all_written() && ($urandom_range(0, 11) == 0);
      send_load(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_elem(), go);
    end
    start <= 1'b0;

    while (plane_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("sent %0d load beats with %0d compute runs", beats_sent, runs_sent);
    $display("checked %0d plane beats, %0d degenerate", planes_seen, degen_seen);
    if (mismatches == 0 && plane_q.size() == 0) begin
      $display("frustum_plane_extract_tb passed");
    end else begin
      $display("frustum_plane_extract_tb failed");
    end
    $finish;
  end

endmodule
